@@ hdl/sorted_matrix_search_defines.svh @@
`ifndef SORTED_MATRIX_SEARCH_DEFINES_SVH
`define SORTED_MATRIX_SEARCH_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SMS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sorted_matrix_search: check failed");

// Next-cycle implication, checked outside reset.
`define SMS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted_matrix_search: check failed");

`endif

@@ hdl/smsrch_pkg.sv @@
`timescale 1ns / 1ps

package smsrch_pkg;

  localparam int ROW_IDX_W  = 6;
  localparam int COL_IDX_W  = 6;
  localparam int VALUE_W    = 32;
  localparam int CFG_DATA_W = 7;
  localparam int CFG_IDX_W  = 1;

  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS_IN_USE = 1'b0,
    CFG_COLS_IN_USE = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_COL_STEP,
    S_COL_CMP,
    S_COL_HIT,
    S_ROW_STEP,
    S_ROW_CMP,
    S_ROW_HIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic done;
    logic hit;
  } status_t;

endpackage

@@ hdl/sorted_matrix_search.sv @@
// A write item gives no result; one item is accepted at a time.
// A search runs up to two lower-bound passes over the single store read port, with at most
// floor(log2(n))+1 probes for n rows or columns in use; in_ready rises again in the same cycle
// that the result becomes valid.
// A result still waiting in the output register holds the next search in its last state.
// Synchronous reset sets rows_in_use to 0, cols_in_use to 1 and empties the result stage.
`timescale 1ns / 1ps

module sorted_matrix_search #(
  parameter int MAX_ROWS   = 64,
  parameter int MAX_COLS   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 mode,
  input  logic [smsrch_pkg::ROW_IDX_W-1:0]     row_index,
  input  logic [smsrch_pkg::COL_IDX_W-1:0]     col_index,
  input  logic signed [smsrch_pkg::VALUE_W-1:0] value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 found,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [smsrch_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [smsrch_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  logic [smsrch_pkg::CFG_DATA_W-1:0] rows_in_use;
  logic [smsrch_pkg::CFG_DATA_W-1:0] cols_in_use;

  logic                         in_accept;
  logic                         start;
  logic                         wr_en;
  logic signed [DATA_WIDTH-1:0] key;
  logic                         ctrl_idle;
  logic                         out_free;
  logic                         rd_en;
  logic [RW-1:0]                rd_row;
  logic [CW-1:0]                rd_col;
  logic signed [DATA_WIDTH-1:0] rd_data;
  smsrch_pkg::status_t          status;

  assign cfg_ready = 1'b1;
  assign in_ready  = ctrl_idle;
  assign in_accept = in_valid && in_ready;
  assign start     = in_accept && (mode == smsrch_pkg::MODE_SEARCH);
  assign wr_en     = in_accept && (mode == smsrch_pkg::MODE_WRITE)
                     && (32'(row_index) < MAX_ROWS) && (32'(col_index) < MAX_COLS);
  assign key       = DATA_WIDTH'(value);
  assign out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= '0;
      cols_in_use <= smsrch_pkg::CFG_DATA_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (smsrch_pkg::cfg_reg_t'(cfg_index))
        smsrch_pkg::CFG_ROWS_IN_USE: rows_in_use <= cfg_data;
        smsrch_pkg::CFG_COLS_IN_USE: cols_in_use <= cfg_data;
        default: ;
      endcase
    end
  end

  smsrch_store #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_row  (RW'(row_index)),
    .wr_col  (CW'(col_index)),
    .wr_data (key),
    .rd_en   (rd_en),
    .rd_row  (rd_row),
    .rd_col  (rd_col),
    .rd_data (rd_data)
  );

  smsrch_ctrl #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .key      (key),
    .rows_cfg (rows_in_use),
    .cols_cfg (cols_in_use),
    .out_free (out_free),
    .idle     (ctrl_idle),
    .rd_en    (rd_en),
    .rd_row   (rd_row),
    .rd_col   (rd_col),
    .rd_data  (rd_data),
    .status   (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (status.done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (status.done) begin
      found <= status.hit;
    end
  end

endmodule

@@ hdl/smsrch_store.sv @@
`timescale 1ns / 1ps

module smsrch_store #(
  parameter int MAX_ROWS   = 64,
  parameter int MAX_COLS   = 64,
  parameter int DATA_WIDTH = 32,
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [RW-1:0]                wr_row,
  input  logic [CW-1:0]                wr_col,
  input  logic signed [DATA_WIDTH-1:0] wr_data,
  input  logic                         rd_en,
  input  logic [RW-1:0]                rd_row,
  input  logic [CW-1:0]                rd_col,
  output logic signed [DATA_WIDTH-1:0] rd_data
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]         wr_addr;
  logic [AW-1:0]         rd_addr;

  assign wr_addr = AW'(32'(wr_row) * MAX_COLS + 32'(wr_col));
  assign rd_addr = AW'(32'(rd_row) * MAX_COLS + 32'(rd_col));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hdl/smsrch_ctrl.sv @@
`timescale 1ns / 1ps

module smsrch_ctrl #(
  parameter int MAX_ROWS   = 64,
  parameter int MAX_COLS   = 64,
  parameter int DATA_WIDTH = 32,
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [DATA_WIDTH-1:0]        key,
  input  logic [smsrch_pkg::CFG_DATA_W-1:0]   rows_cfg,
  input  logic [smsrch_pkg::CFG_DATA_W-1:0]   cols_cfg,
  input  logic                                out_free,
  output logic                                idle,
  output logic                                rd_en,
  output logic [RW-1:0]                       rd_row,
  output logic [CW-1:0]                       rd_col,
  input  logic signed [DATA_WIDTH-1:0]        rd_data,
  output smsrch_pkg::status_t                 status
);

  localparam int RNW = $clog2(MAX_ROWS + 1);
  localparam int CNW = $clog2(MAX_COLS + 1);
  localparam int IW  = (RNW > CNW) ? RNW : CNW;

  smsrch_pkg::state_t state, state_next;

  logic [IW-1:0]                first, first_next;
  logic [IW-1:0]                count, count_next;
  logic [IW-1:0]                n_lim, n_next;
  logic [IW-1:0]                c_lim, c_next;
  logic [RW-1:0]                row_sel, row_next;
  logic signed [DATA_WIDTH-1:0] key_q, key_next;
  logic                         hit, hit_next;

  logic [IW-1:0] step;
  logic [IW-1:0] mid;
  logic [IW-1:0] rows_clamp;
  logic [IW-1:0] cols_clamp;
  logic          gt;
  logic          eq;

  assign step = count >> 1;
  assign mid  = first + step;
  assign gt   = key_q > rd_data;
  assign eq   = key_q == rd_data;

  assign rows_clamp = (32'(rows_cfg) > MAX_ROWS) ? IW'(MAX_ROWS) : IW'(rows_cfg);
  assign cols_clamp = (32'(cols_cfg) > MAX_COLS) ? IW'(MAX_COLS) : IW'(cols_cfg);

  always_comb begin
    state_next = state;
    case (state)
      smsrch_pkg::S_IDLE: begin
        if (start) begin
          if (rows_clamp == '0 || cols_clamp == '0) begin
            state_next = smsrch_pkg::S_DONE;
          end else begin
            state_next = smsrch_pkg::S_COL_STEP;
          end
        end
      end
      smsrch_pkg::S_COL_STEP: begin
        if (count != '0) begin
          state_next = smsrch_pkg::S_COL_CMP;
        end else if (first < n_lim) begin
          state_next = smsrch_pkg::S_COL_HIT;
        end else begin
          state_next = smsrch_pkg::S_ROW_STEP;
        end
      end
      smsrch_pkg::S_COL_CMP: state_next = smsrch_pkg::S_COL_STEP;
      smsrch_pkg::S_COL_HIT: begin
        if (eq || first == '0) begin
          state_next = smsrch_pkg::S_DONE;
        end else begin
          state_next = smsrch_pkg::S_ROW_STEP;
        end
      end
      smsrch_pkg::S_ROW_STEP: begin
        if (count != '0) begin
          state_next = smsrch_pkg::S_ROW_CMP;
        end else if (first < c_lim) begin
          state_next = smsrch_pkg::S_ROW_HIT;
        end else begin
          state_next = smsrch_pkg::S_DONE;
        end
      end
      smsrch_pkg::S_ROW_CMP: state_next = smsrch_pkg::S_ROW_STEP;
      smsrch_pkg::S_ROW_HIT: state_next = smsrch_pkg::S_DONE;
      smsrch_pkg::S_DONE: begin
        if (out_free) begin
          state_next = smsrch_pkg::S_IDLE;
        end
      end
      default: state_next = smsrch_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    idle        = 1'b0;
    rd_en       = 1'b0;
    rd_row      = row_sel;
    rd_col      = '0;
    status.done = 1'b0;
    status.hit  = hit;
    case (state)
      smsrch_pkg::S_IDLE: idle = 1'b1;
      smsrch_pkg::S_COL_STEP: begin
        rd_en  = (count != '0) || (first < n_lim);
        rd_row = (count != '0) ? RW'(mid) : RW'(first);
      end
      smsrch_pkg::S_ROW_STEP: begin
        rd_en  = (count != '0) || (first < c_lim);
        rd_col = (count != '0) ? CW'(mid) : CW'(first);
      end
      smsrch_pkg::S_DONE: status.done = out_free;
      default: ;
    endcase
  end

  always_comb begin
    first_next = first;
    count_next = count;
    n_next     = n_lim;
    c_next     = c_lim;
    row_next   = row_sel;
    key_next   = key_q;
    hit_next   = hit;
    case (state)
      smsrch_pkg::S_IDLE: begin
        if (start) begin
          key_next   = key;
          n_next     = rows_clamp;
          c_next     = cols_clamp;
          first_next = '0;
          count_next = rows_clamp;
          hit_next   = 1'b0;
        end
      end
      smsrch_pkg::S_COL_STEP: begin
        if (count == '0 && !(first < n_lim)) begin
          row_next   = RW'(n_lim - 1'b1);
          first_next = '0;
          count_next = c_lim;
        end
      end
      smsrch_pkg::S_COL_CMP, smsrch_pkg::S_ROW_CMP: begin
        if (gt) begin
          first_next = mid + 1'b1;
          count_next = count - step - 1'b1;
        end else begin
          count_next = step;
        end
      end
      smsrch_pkg::S_COL_HIT: begin
        if (eq) begin
          hit_next = 1'b1;
        end else if (first != '0) begin
          row_next   = RW'(first - 1'b1);
          first_next = '0;
          count_next = c_lim;
        end
      end
      smsrch_pkg::S_ROW_HIT: hit_next = eq;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= smsrch_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    first   <= first_next;
    count   <= count_next;
    n_lim   <= n_next;
    c_lim   <= c_next;
    row_sel <= row_next;
    key_q   <= key_next;
    hit     <= hit_next;
  end

endmodule

@@ hdl/smsrch_checker.sv @@
`timescale 1ns / 1ps
`include "sorted_matrix_search_defines.svh"

module smsrch_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic mode,
  input logic out_valid,
  input logic out_ready,
  input logic found
);

  `SMS_ASSERT_NEXT(a_result_held, clk, rst, out_valid && !out_ready, out_valid && $stable(found))
  `SMS_ASSERT_NEXT(a_write_no_result, clk, rst, in_valid && in_ready && !mode && !out_valid, !out_valid)
  `SMS_ASSERT_NEXT(a_search_busy, clk, rst, in_valid && in_ready && mode, !in_ready)
  `SMS_ASSERT_NOW(a_result_from_search, clk, rst, $rose(out_valid), !$past(in_ready))

endmodule

bind sorted_matrix_search smsrch_checker u_checker (.*);
